// ===== hw/rtl/dddiff_pkg.sv =====
// ----------------------------------------------------------------------------
// dddiff_pkg
// Types, constants and calendar tables shared by the date difference unit.
// ----------------------------------------------------------------------------
package dddiff_pkg;

	localparam logic [13:0] YEAR_MIN  = 14'd1;
	localparam logic [13:0] YEAR_MAX  = 14'd9999;
	localparam logic [3:0]  MONTH_JAN = 4'd1;
	localparam logic [3:0]  MONTH_FEB = 4'd2;
	localparam logic [3:0]  MONTH_DEC = 4'd12;
	// floor(x / 100) == (x * RECIP_100) >> 19 for every 14-bit x
	localparam logic [12:0] RECIP_100 = 13'd5243;

	typedef struct packed {
		logic [4:0]  day;
		logic [3:0]  month;
		logic [13:0] year;
	} date_t;

	typedef struct packed {
		logic        ok;
		logic [21:0] num;
	} day_num_t;

	function automatic logic [8:0] days_before_month(input logic [3:0] m);
		logic [8:0] r;
		case (m)
			4'd1:    r = 9'd0;
			4'd2:    r = 9'd31;
			4'd3:    r = 9'd59;
			4'd4:    r = 9'd90;
			4'd5:    r = 9'd120;
			4'd6:    r = 9'd151;
			4'd7:    r = 9'd181;
			4'd8:    r = 9'd212;
			4'd9:    r = 9'd243;
			4'd10:   r = 9'd273;
			4'd11:   r = 9'd304;
			4'd12:   r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] r;
		case (m)
			4'd2:                      r = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
			default:                   r = 5'd31;
		endcase
		return r;
	endfunction

endpackage

// ===== hw/rtl/dddiff_day_number.sv =====
// ----------------------------------------------------------------------------
// dddiff_day_number
// Three-stage pipeline: ordinal day number of one date and its existence check.
// ----------------------------------------------------------------------------
module dddiff_day_number (
	input  logic                 clk,
	input  logic                 en,
	input  dddiff_pkg::date_t    date,
	output dddiff_pkg::day_num_t day_num
);
	import dddiff_pkg::*;

	// stage 1 signals
	logic [13:0] year_prev;
	logic [26:0] cent_prod;
	logic [4:0]  day_s1;
	logic [3:0]  month_s1;
	logic [13:0] year_s1;
	logic [13:0] year_prev_s1;
	logic [7:0]  cent_s1;
	logic        ok_s1;

	// stage 2 signals
	logic [14:0] cent_x100;
	logic [14:0] rem_full;
	logic [6:0]  rem;
	logic        div100;
	logic [7:0]  cent_y;
	logic        leap;
	logic [22:0] base365;
	logic [11:0] corr;
	logic [8:0]  offs;
	logic [22:0] base365_s2;
	logic [11:0] corr_s2;
	logic [8:0]  offs_s2;
	logic        ok_s2;

	// stage 3 signals
	logic [22:0] sum;
	logic [21:0] num_s3;
	logic        ok_s3;

	assign year_prev = date.year - 14'd1;
	assign cent_prod = 27'(year_prev) * 27'(RECIP_100);

	always_ff @(posedge clk) begin
		if (en) begin
			day_s1       <= date.day;
			month_s1     <= date.month;
			year_s1      <= date.year;
			year_prev_s1 <= year_prev;
			cent_s1      <= cent_prod[26:19];
			ok_s1        <= (date.year >= YEAR_MIN) && (date.year <= YEAR_MAX) &&
			                (date.month >= MONTH_JAN) && (date.month <= MONTH_DEC) &&
			                (date.day != 5'd0);
		end
	end

	// leap year from the century quotient of the previous year
	assign cent_x100 = 15'(cent_s1) * 15'd100;
	assign rem_full  = {1'b0, year_prev_s1} - cent_x100;
	assign rem       = rem_full[6:0];
	assign div100    = (rem == 7'd99);
	assign cent_y    = cent_s1 + {7'd0, div100};
	assign leap      = (year_s1[1:0] == 2'd0) && (!div100 || (cent_y[1:0] == 2'd0));
	assign base365   = 23'(year_prev_s1) * 23'd365;
	assign corr      = 12'(year_prev_s1[13:2]) - 12'(cent_s1) + 12'(cent_s1[7:2]);
	assign offs      = days_before_month(month_s1) + 9'(day_s1) +
	                   9'((month_s1 > MONTH_FEB) && leap);

	always_ff @(posedge clk) begin
		if (en) begin
			base365_s2 <= base365;
			corr_s2    <= corr;
			offs_s2    <= offs;
			ok_s2      <= ok_s1 && (day_s1 <= month_len(month_s1, leap));
		end
	end

	assign sum = base365_s2 + 23'(corr_s2) + 23'(offs_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			num_s3 <= sum[21:0];
			ok_s3  <= ok_s2;
		end
	end

	assign day_num.ok  = ok_s3;
	assign day_num.num = num_s3;

endmodule

// ===== hw/rtl/date_difference_in_days_unit.sv =====
// An input passes the day-number pipeline stages, then the difference and output registers.
// Throughput: one date pair per cycle while the output is not stalled; two day-number pipelines run side by side.
// A stalled output holds the whole pipeline in place, so nothing is lost.
// Reset clears the stage valid bits only; the data registers are not reset.
// ----------------------------------------------------------------------------
// date_difference_in_days_unit
// Signed day count between two Gregorian dates, fully pipelined.
// ----------------------------------------------------------------------------
module date_difference_in_days_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [4:0]         first_day,
	input  logic [3:0]         first_month,
	input  logic [13:0]        first_year,
	input  logic [4:0]         second_day,
	input  logic [3:0]         second_month,
	input  logic [13:0]        second_year,
	input  logic               include_end_day,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [22:0] day_difference,
	output logic               dates_valid
);
	import dddiff_pkg::*;

	logic        en;
	date_t       date_a;
	date_t       date_b;
	day_num_t    num_a;
	day_num_t    num_b;

	logic        v_s1, v_s2, v_s3, v_s4, v_s5;
	logic        end_s1, end_s2, end_s3, end_s4;
	logic signed [22:0] diff;
	logic signed [22:0] diff_s4;
	logic        ok_s4;
	logic signed [22:0] diff_s5;
	logic        ok_s5;

	// whole pipeline advances unless a finished result is held
	assign en       = !(v_s5 && out_stall);
	assign in_stall = !en;

	assign date_a = '{day: first_day, month: first_month, year: first_year};
	assign date_b = '{day: second_day, month: second_month, year: second_year};

	dddiff_day_number u_num_a (
		.clk     (clk),
		.en      (en),
		.date    (date_a),
		.day_num (num_a)
	);

	dddiff_day_number u_num_b (
		.clk     (clk),
		.en      (en),
		.date    (date_b),
		.day_num (num_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	assign diff = $signed({1'b0, num_b.num}) - $signed({1'b0, num_a.num});

	always_ff @(posedge clk) begin
		if (en) begin
			end_s1  <= include_end_day;
			end_s2  <= end_s1;
			end_s3  <= end_s2;
			end_s4  <= end_s3;
			diff_s4 <= diff;
			ok_s4   <= num_a.ok && num_b.ok;
			ok_s5   <= ok_s4;
			if (!ok_s4) begin
				diff_s5 <= '0;
			end else if (end_s4) begin
				diff_s5 <= diff_s4[22] ? diff_s4 - 23'sd1 : diff_s4 + 23'sd1;
			end else begin
				diff_s5 <= diff_s4;
			end
		end
	end

	assign out_valid      = v_s5;
	assign day_difference = diff_s5;
	assign dates_valid    = ok_s5;

	// an invalid date pair always reports zero days
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !dates_valid |-> day_difference == 23'sd0)
		else $error("invalid dates with nonzero difference");

	// an accepted transfer enters the first stage
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> v_s1)
		else $error("accepted transfer lost at entry");

	// a held pipeline keeps its valid bits
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> v_s1 == $past(v_s1) && v_s4 == $past(v_s4) && v_s5 == $past(v_s5))
		else $error("pipeline moved while held");

	// the last stage hands on to the output
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		en && v_s4 |=> out_valid)
		else $error("result lost between last stages");

endmodule
